// ===== rtl/core/bqpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqpc_pkg: shared types and constants of the quadrature position counter
// Transaction payloads, configuration view, operation and register codes,
// and the x4 transition table.
// ----------------------------------------------------------------------------
package bqpc_pkg;

	localparam int FINE_POSITION_BITS_DEF = 21;
	localparam int CFG_INDEX_BITS         = 3;
	localparam int CFG_DATA_BITS          = 16;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_PRESET = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_VALUE        = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VALUE        = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_AROUND      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_PER_DETENT = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLED          = 3'd4;

	localparam logic signed [15:0] MIN_VALUE_RST = -16'sd32768;
	localparam logic signed [15:0] MAX_VALUE_RST = 16'sd32767;
	localparam logic [4:0]         STEPS_RST     = 5'd4;

	typedef struct packed {
		logic [1:0]         operation;
		logic               pin_a;
		logic               pin_b;
		logic signed [15:0] preset_value;
	} req_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic signed [15:0] change;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic               wrap_around;
		logic [4:0]         steps;
		logic               enabled;
	} cfg_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
		logic negative;
	} div_stat_t;

	function automatic logic signed [1:0] step_of(input logic [3:0] idx);
		logic signed [1:0] r;
		unique case (idx)
			4'h1, 4'h7, 4'h8, 4'he: r = -2'sd1;
			4'h2, 4'h4, 4'hb, 4'hd: r = 2'sd1;
			default:                r = 2'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bounded_quadrature_position_counter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_quadrature_position_counter_core: x4 quadrature position counter
// Sequencer with one shared multiplier for bound and preset scaling, a
// bound stage and a bit-serial divider for the reported position.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A pin sample or preset passes from
// acceptance through lower bound, upper bound and, for a preset only,
// preset scaling on the shared multiplier, then the bound stage and the
// divider, which yields one quotient bit per cycle, to a registered
// result; a change query or an ignored sample goes straight to the divider.
// A finished result waits in the output register while the next
// transaction is accepted; while the previous result is still stalled, a
// new one holds in the last step.
module bounded_quadrature_position_counter_core #(
	parameter int FINE_POSITION_BITS = bqpc_pkg::FINE_POSITION_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire bqpc_pkg::req_t                      req,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output bqpc_pkg::rsp_t                           rsp,
	input  wire logic                                cfg_wr_en,
	input  wire logic [bqpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bqpc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int W  = FINE_POSITION_BITS;
	localparam int PW = 22;
	localparam int VW = (W + 1 > PW) ? W + 1 : PW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_MUL_PRE,
		ST_BOUND, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
	} state_t;

	bqpc_pkg::cfg_t      cfg;
	bqpc_pkg::div_ctrl_t div_ctrl;
	bqpc_pkg::div_stat_t div_stat;
	logic [W-1:0]        div_quo;

	state_t               state_q;
	logic [1:0]           op_q;
	logic signed [15:0]   preset_q;
	logic [1:0]           prev_q;
	logic signed [W-1:0]  fine_q;
	logic signed [PW-1:0] lo_q;
	logic signed [PW-1:0] hi_q;
	logic signed [VW-1:0] cand_q;
	logic signed [15:0]   last_q;
	logic                 rsp_valid_q;
	bqpc_pkg::rsp_t       rsp_q;

	logic signed [15:0]   mul_a;
	logic signed [PW-1:0] mul_ax;
	logic signed [PW-1:0] mul_sx;
	logic signed [PW-1:0] prod;
	logic signed [VW-1:0] lo_x;
	logic signed [VW-1:0] hi_x;
	logic signed [VW-1:0] v_hi;
	logic signed [VW-1:0] v_lo;
	logic [1:0]           cur_ph;
	logic signed [1:0]    step;
	logic signed [15:0]   pos;
	logic                 accept;
	logic                 emit;

	bqpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bqpc_divider #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (fine_q),
		.divisor  (cfg.steps),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign accept         = req_valid && !req_stall;
	assign req_stall      = (state_q != ST_IDLE);
	assign div_ctrl.start = (state_q == ST_DIV_GO);
	assign emit           = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		unique case (state_q)
			ST_MUL_LO: mul_a = cfg.min_value;
			ST_MUL_HI: mul_a = cfg.max_value;
			default:   mul_a = preset_q;
		endcase
	end

	assign mul_ax = PW'(mul_a);
	assign mul_sx = $signed({{(PW-5){1'b0}}, cfg.steps});
	assign prod   = mul_ax * mul_sx;

	assign lo_x = VW'(lo_q);
	assign hi_x = VW'(hi_q);
	assign v_hi = (cand_q > hi_x) ? (cfg.wrap_around ? lo_x : hi_x) : cand_q;
	assign v_lo = (v_hi < lo_x) ? (cfg.wrap_around ? hi_x : lo_x) : v_hi;

	assign cur_ph = {req.pin_b, req.pin_a};
	assign step   = bqpc_pkg::step_of({prev_q, cur_ph});
	assign pos    = div_stat.negative ? $signed(~div_quo[15:0] + 16'd1)
	                                  : $signed(div_quo[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= bqpc_pkg::OP_SAMPLE;
			preset_q    <= '0;
			prev_q      <= '0;
			fine_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			cand_q      <= '0;
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= req.operation;
						preset_q <= req.preset_value;
						cand_q   <= VW'(fine_q) + VW'(step);
						if (req.operation == bqpc_pkg::OP_SAMPLE && cfg.enabled) begin
							prev_q  <= cur_ph;
							state_q <= ST_MUL_LO;
						end else if (req.operation == bqpc_pkg::OP_PRESET) begin
							state_q <= ST_MUL_LO;
						end else begin
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_MUL_LO: begin
					lo_q    <= prod;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					hi_q    <= prod;
					state_q <= (op_q == bqpc_pkg::OP_PRESET) ? ST_MUL_PRE : ST_BOUND;
				end
				ST_MUL_PRE: begin
					cand_q  <= VW'(prod);
					state_q <= ST_BOUND;
				end
				ST_BOUND: begin
					fine_q  <= v_lo[W-1:0];
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (emit) begin
						rsp_q.position <= pos;
						rsp_q.change   <= pos - last_q;
						if (op_q == bqpc_pkg::OP_QUERY)
							last_q <= pos;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside the wait state");

	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DONE |=> $stable(last_q))
		else $error("queried position moved outside result write");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!rsp_valid_q || !rsp_stall) |=>
		rsp_valid_q && state_q == ST_IDLE)
		else $error("result not presented on leaving done");

	a_fine_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_BOUND |=> $stable(fine_q))
		else $error("fine position changed outside bound step");

endmodule
`default_nettype wire

// ===== rtl/core/bqpc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqpc_cfg: configuration register file
// Holds bounds, wrap mode, steps per detent and enable; presents the
// effective step count (zero read as one).
// ----------------------------------------------------------------------------
module bqpc_cfg (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [bqpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [bqpc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output bqpc_pkg::cfg_t                             cfg
);

	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic               wrap_q;
	logic [4:0]         steps_q;
	logic               enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= bqpc_pkg::MIN_VALUE_RST;
			max_q     <= bqpc_pkg::MAX_VALUE_RST;
			wrap_q    <= 1'b0;
			steps_q   <= bqpc_pkg::STEPS_RST;
			enabled_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bqpc_pkg::REG_MIN_VALUE:        min_q     <= $signed(cfg_data);
				bqpc_pkg::REG_MAX_VALUE:        max_q     <= $signed(cfg_data);
				bqpc_pkg::REG_WRAP_AROUND:      wrap_q    <= cfg_data[0];
				bqpc_pkg::REG_STEPS_PER_DETENT: steps_q   <= cfg_data[4:0];
				bqpc_pkg::REG_ENABLED:          enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.min_value   = min_q;
		cfg.max_value   = max_q;
		cfg.wrap_around = wrap_q;
		cfg.steps       = (steps_q == 5'd0) ? 5'd1 : steps_q;
		cfg.enabled     = enabled_q;
	end

endmodule
`default_nettype wire

// ===== rtl/core/bqpc_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqpc_divider: bit-serial signed divider
// Divides the fine position magnitude by the step count, one quotient bit
// per cycle through a shared subtract and compare; the sign is returned
// apart for the caller to apply.
// ----------------------------------------------------------------------------
module bqpc_divider #(
	parameter int W = bqpc_pkg::FINE_POSITION_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bqpc_pkg::div_ctrl_t ctrl,
	input  wire logic signed [W-1:0] dividend,
	input  wire logic [4:0]          divisor,
	output bqpc_pkg::div_stat_t      stat,
	output logic [W-1:0]             quotient
);

	localparam int CW = $clog2(W + 1);

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t         dstate_q;
	logic [CW-1:0]   cnt_q;
	logic [5:0]      rem_q;
	logic [W-1:0]    quo_q;
	logic [4:0]      div_q;
	logic            neg_q;
	logic            done_q;
	logic [5:0]      rem_sh;
	logic            fits;

	assign rem_sh = {rem_q[4:0], quo_q[W-1]};
	assign fits   = (rem_sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= D_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			div_q    <= 5'd1;
			neg_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (dstate_q)
				D_IDLE: begin
					if (ctrl.start) begin
						quo_q    <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
						neg_q    <= dividend[W-1];
						div_q    <= divisor;
						rem_q    <= '0;
						cnt_q    <= CW'(W);
						dstate_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
					quo_q <= {quo_q[W-2:0], fits};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						done_q   <= 1'b1;
						dstate_q <= D_IDLE;
					end
				end
				default: dstate_q <= D_IDLE;
			endcase
		end
	end

	assign stat.done     = done_q;
	assign stat.negative = neg_q;
	assign quotient      = quo_q;

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		dstate_q == D_RUN |-> cnt_q != '0)
		else $error("divider running with exhausted count");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		dstate_q == D_RUN |-> rem_q < {1'b0, div_q})
		else $error("partial remainder not below divisor");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(dstate_q == D_RUN))
		else $error("divider done without a run");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: bounded quadrature position counter core
// Drives pin samples, presets and change queries through the valid/stall
// request channel, predicts every reading in step with the block's own state
// and compares each accepted reading field by field. Directed tests hit the
// bounds, the transition table, wrap, crossed bounds and disabled counting;
// random phases then walk the encoder under many register settings.
// ----------------------------------------------------------------------------
module testbench;
	import bqpc_pkg::*;

	localparam int         FPB          = FINE_POSITION_BITS_DEF;
	localparam int         CYCLE_LIMIT  = 500000;
	localparam int         DRAIN_CYCLES = FPB + 12;
	localparam int         PHASES       = 10;
	localparam int         PHASE_ITEMS  = 70;
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	localparam int         STEP_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1,
						  -1, 0, 0, 1, 0, 1, -1, 0};
	localparam logic [1:0] WALK_RING  [4]  = '{2'd0, 2'd2, 2'd3, 2'd1};

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	req_t                      req       = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	rsp_t                      rsp;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// predictor copy of registers and counter state
	logic signed [15:0]    cfg_min;
	logic signed [15:0]    cfg_max;
	logic                  cfg_wrap;
	logic [4:0]            cfg_steps;
	logic                  cfg_en;
	logic [1:0]            cnt_phases;
	logic signed [FPB-1:0] cnt_fine;
	logic signed [15:0]    cnt_last;

	rsp_t expected_readings [$];

	int tx_idle_pct    = 16;
	int rx_idle_pct    = 85;
	int errors         = 0;
	int cycle_count    = 0;
	int settings_count = 0;
	int op_count [4]   = '{0, 0, 0, 0};
	int walk_pos       = 0;
	int walk_dir       = 1;

	bounded_quadrature_position_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint eff_steps();
		return (cfg_steps == 5'd0) ? 64'sd1 : longint'(cfg_steps);
	endfunction

	function automatic void store_bounded(input longint v);
		longint s;
		longint lo;
		longint hi;
		longint b;
		s  = eff_steps();
		lo = longint'($signed(cfg_min)) * s;
		hi = longint'($signed(cfg_max)) * s;
		b  = v;
		if (b > hi) b = cfg_wrap ? lo : hi;
		if (b < lo) b = cfg_wrap ? hi : lo;
		cnt_fine = b[FPB-1:0];
	endfunction

	function automatic rsp_t predict_reading(input req_t it);
		rsp_t               r;
		logic [1:0]         cur;
		logic [3:0]         idx;
		longint             q;
		logic signed [15:0] pos;
		case (it.operation)
			OP_SAMPLE: begin
				if (cfg_en) begin
					cur        = {it.pin_b, it.pin_a};
					idx        = {cnt_phases, cur};
					cnt_phases = cur;
					store_bounded(longint'(cnt_fine) + STEP_DELTA[idx]);
				end
			end
			OP_PRESET: store_bounded(longint'($signed(it.preset_value)) * eff_steps());
			default: ;
		endcase
		q          = longint'(cnt_fine) / eff_steps();
		pos        = q[15:0];
		r.position = pos;
		r.change   = pos - cnt_last;
		if (it.operation == OP_QUERY) cnt_last = pos;
		return r;
	endfunction

	function automatic req_t make_item(input logic [1:0] op, input logic [1:0] ph,
					   input logic [15:0] val);
		req_t it;
		it.operation    = op;
		it.pin_b        = ph[1];
		it.pin_a        = ph[0];
		it.preset_value = val;
		return it;
	endfunction

	function automatic req_t random_item();
		req_t it;
		int   r;
		it = make_item(OP_SAMPLE, 2'($urandom_range(3)), 16'($urandom));
		r  = $urandom_range(99);
		if (r < 65) begin
			if ($urandom_range(9) == 0) walk_dir = -walk_dir;
			walk_pos = (walk_pos + walk_dir) & 3;
			{it.pin_b, it.pin_a} = WALK_RING[walk_pos];
		end else if (r < 73) begin
			// leave the random pins: broken sequence
		end else if (r < 85) begin
			it.operation = OP_PRESET;
			case ($urandom_range(5))
				0: it.preset_value = cfg_min;
				1: it.preset_value = cfg_max;
				2: it.preset_value = cfg_min - 16'sd1;
				3: it.preset_value = cfg_max + 16'sd1;
				4: it.preset_value = 16'($signed($urandom_range(16)) - 8);
				default: ;
			endcase
		end else if (r < 96) begin
			it.operation = OP_QUERY;
		end else begin
			it.operation = OP_UNUSED;
		end
		return it;
	endfunction

	task automatic send_item(input req_t it);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_readings.push_back(predict_reading(it));
		op_count[it.operation]++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic signed [15:0] mn, input logic signed [15:0] mx,
				 input logic wr, input logic [4:0] st, input logic en);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MIN_VALUE;
		cfg_data  <= mn;
		@(posedge clk);
		cfg_min   = mn;
		cfg_index <= REG_MAX_VALUE;
		cfg_data  <= mx;
		@(posedge clk);
		cfg_max   = mx;
		cfg_index <= REG_WRAP_AROUND;
		cfg_data  <= {15'd0, wr};
		@(posedge clk);
		cfg_wrap  = wr;
		cfg_index <= REG_STEPS_PER_DETENT;
		cfg_data  <= {11'd0, st};
		@(posedge clk);
		cfg_steps = st;
		cfg_index <= REG_ENABLED;
		cfg_data  <= {15'd0, en};
		@(posedge clk);
		cfg_en    = en;
		cfg_wr_en <= 1'b0;
		settings_count++;
	endtask

	// walk forward a detent, back part way, then an illegal double-phase jump
	task automatic test_reset_state();
		send_item(make_item(OP_QUERY, 2'd0, 16'h0000));
		send_item(make_item(OP_SAMPLE, 2'd2, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd3, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd1, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd0, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd1, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd3, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd0, 16'($urandom)));
		send_item(make_item(OP_QUERY, 2'd3, 16'hffff));
	endtask

	task automatic test_preset_limits();
		send_item(make_item(OP_PRESET, 2'd3, 16'h7fff));
		send_item(make_item(OP_SAMPLE, 2'd2, 16'h0000));
		send_item(make_item(OP_PRESET, 2'd0, 16'h8000));
		send_item(make_item(OP_SAMPLE, 2'd0, 16'hffff));
		send_item(make_item(OP_UNUSED, 2'd3, 16'hffff));
		send_item(make_item(OP_QUERY, 2'd0, 16'h0000));
	endtask

	task automatic test_wrap_and_disable();
		configure(-16'sd1, 16'sd1, 1'b1, 5'd0, 1'b1);
		send_item(make_item(OP_PRESET, 2'd0, 16'h0001));
		send_item(make_item(OP_SAMPLE, 2'd2, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd0, 16'($urandom)));
		configure(-16'sd1, 16'sd1, 1'b1, 5'd0, 1'b0);
		send_item(make_item(OP_SAMPLE, 2'd2, 16'($urandom)));
		send_item(make_item(OP_SAMPLE, 2'd3, 16'($urandom)));
		send_item(make_item(OP_PRESET, 2'd1, 16'h0000));
		configure(-16'sd1, 16'sd1, 1'b1, 5'd0, 1'b1);
		send_item(make_item(OP_SAMPLE, 2'd2, 16'($urandom)));
		send_item(make_item(OP_QUERY, 2'd0, 16'h0000));
	endtask

	task automatic test_crossed_bounds();
		configure(16'sd5, -16'sd5, 1'b0, 5'd31, 1'b1);
		send_item(make_item(OP_PRESET, 2'd0, 16'h0000));
		send_item(make_item(OP_QUERY, 2'd0, 16'h0000));
		configure(16'sd5, -16'sd5, 1'b1, 5'd31, 1'b1);
		send_item(make_item(OP_PRESET, 2'd0, 16'h0000));
		send_item(make_item(OP_SAMPLE, 2'd2, 16'($urandom)));
	endtask

	task automatic test_random_settings();
		logic signed [15:0] mn;
		logic signed [15:0] mx;
		logic [4:0]         st;
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(4))
				0:       mn = -16'sd32768;
				1:       mn = 16'($urandom);
				default: mn = -16'($urandom_range(6));
			endcase
			case ($urandom_range(4))
				0:       mx = 16'sd32767;
				1:       mx = 16'($urandom);
				default: mx = 16'($urandom_range(6));
			endcase
			if ($urandom_range(3) == 0)
				st = ($urandom_range(2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
			else
				st = 5'($urandom_range(1, 16));
			if (p == 0)
				configure(-16'sd32768, 16'sd32767, 1'b0, 5'd31, 1'b1);
			else if (p == 1)
				configure(-16'sd32768, 16'sd32767, 1'b1, 5'd1, 1'b1);
			else if (p == 2)
				configure(-16'sd3, 16'sd3, 1'b0, 5'd16, 1'b1);
			else
				configure(mn, mx, 1'($urandom_range(1)), st, $urandom_range(7) != 0);
			if (p < 4) begin
				tx_idle_pct = 16;
				rx_idle_pct = 85;
			end else if (p < 7) begin
				tx_idle_pct = 85;
				rx_idle_pct = 16;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == PHASE_ITEMS / 2) drain();
				send_item(random_item());
			end
		end
	endtask

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if (rsp_valid && !rsp_stall) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: reading with none expected: position %0d change %0d",
					 $time, rsp.position, rsp.change);
				errors++;
			end else begin
				exp_r = expected_readings.pop_front();
				if (rsp.position !== exp_r.position) begin
					$display("%0t: position mismatch: expected %0d, actual %0d",
						 $time, exp_r.position, rsp.position);
					errors++;
				end
				if (rsp.change !== exp_r.change) begin
					$display("%0t: change mismatch: expected %0d, actual %0d",
						 $time, exp_r.change, rsp.change);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d readings outstanding",
				 cycle_count, expected_readings.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		cfg_min    = MIN_VALUE_RST;
		cfg_max    = MAX_VALUE_RST;
		cfg_wrap   = 1'b0;
		cfg_steps  = STEPS_RST;
		cfg_en     = 1'b1;
		cnt_phases = 2'd0;
		cnt_fine   = '0;
		cnt_last   = 16'sd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_preset_limits();
		test_wrap_and_disable();
		test_crossed_bounds();
		test_random_settings();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d samples, %0d presets, %0d change queries, %0d unused codes",
			 op_count[OP_SAMPLE], op_count[OP_PRESET], op_count[OP_QUERY],
			 op_count[OP_UNUSED]);
		$display("over %0d register settings: clamp, wrap, crossed bounds, disabled, steps 0-31",
			 settings_count);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bqpc_pkg.sv
rtl/core/bqpc_cfg.sv
rtl/core/bqpc_divider.sv
rtl/core/bounded_quadrature_position_counter_core.sv
tb/sv/testbench.sv
